/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; all checks are clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Condition must never be true
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

/* hw/rtl/mfs_pkg.sv */
// ----------------------------------------------------------------------------
// mfs_pkg
// Types and constants shared by the multilevel feedback scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package mfs_pkg;

    localparam int LEVELS    = 4;
    localparam int LVL_W     = 2;
    localparam int MAX_TASKS = 64;
    localparam int TID_W     = 6;
    localparam int MAX_CPUS  = 8;
    localparam int CNT_W     = 7;   // per-level fill count, 0..MAX_TASKS
    localparam int GCNT_W    = 4;   // grants per tick, 0..MAX_CPUS
    localparam int GIX_W     = 3;   // index into the grant list
    localparam int FADDR_W   = LVL_W + TID_W;
    localparam int SL_W      = 16;  // slice counters and slice length
    localparam int TIME_W    = 32;

    localparam logic [SL_W-1:0] SLICE_SAT = '1;

    // input actions
    localparam logic [1:0] ACT_SUBMIT = 2'd0;
    localparam logic [1:0] ACT_TICK   = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_GRANT  = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_IDLE   = 2'd2;
    localparam logic [1:0] KIND_REJECT = 2'd3;

    // configuration register indexes
    localparam logic REG_CPU_COUNT    = 1'b0;
    localparam logic REG_SLICE_LENGTH = 1'b1;

    typedef struct packed {
        logic [1:0]       action;
        logic [TID_W-1:0] task_id;
        logic [2:0]       priority_req;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [TID_W-1:0]  task_id_out;
        logic [LVL_W-1:0]  level_out;
        logic [TIME_W-1:0] run_time;
        logic [TIME_W-1:0] wait_time;
        logic              last;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_SUBMIT = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_REJECT = 2'd3
    } cmd_code_t;

    // classified item passed from front to back
    typedef struct packed {
        cmd_code_t        code;
        logic [TID_W-1:0] id;
        logic [LVL_W-1:0] lvl;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } front_out_t;

    // per-task record
    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [SL_W-1:0]  run;
        logic [SL_W-1:0]  waits;
    } task_rec_t;

endpackage

`default_nettype wire

/* hw/rtl/mfs_front.sv */
// ----------------------------------------------------------------------------
// mfs_front
// Decodes incoming items, rejects bad actions and priorities, and holds
// classified items in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mfs_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire mfs_pkg::in_item_t item,
    output logic                   busy,
    input  wire logic              pop,
    output mfs_pkg::front_out_t    front_out
);

    mfs_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    fill_reg, fill_next;
    logic          push;
    logic          do_pop;
    mfs_pkg::cmd_t cls;

    // classify the incoming item
    always_comb
    begin
        cls.id  = item.task_id;
        cls.lvl = mfs_pkg::LVL_W'(item.priority_req - 3'd1);
        case (item.action)
            mfs_pkg::ACT_SUBMIT:
            begin
                if (item.priority_req inside {[1:mfs_pkg::LEVELS]})
                    cls.code = mfs_pkg::CMD_SUBMIT;
                else
                    cls.code = mfs_pkg::CMD_REJECT;
            end
            mfs_pkg::ACT_TICK:   cls.code = mfs_pkg::CMD_TICK;
            mfs_pkg::ACT_FINISH: cls.code = mfs_pkg::CMD_FINISH;
            default:             cls.code = mfs_pkg::CMD_REJECT;
        endcase
    end

    assign busy   = (fill_reg == 2'd2);
    assign push   = start && !busy;
    assign do_pop = pop && (fill_reg != 2'd0);

    // queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cls;
    end

    assign front_out.valid = (fill_reg != 2'd0);
    assign front_out.cmd   = q_reg[rd_ptr_reg];

endmodule

`default_nettype wire

/* hw/rtl/mfs_back.sv */
// ----------------------------------------------------------------------------
// mfs_back
// Executes classified items: level FIFOs, task records, tick sweep and
// result generation.
// ----------------------------------------------------------------------------
`default_nettype none

module mfs_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire mfs_pkg::front_out_t         front_out,
    output logic                             pop,
    input  wire logic [mfs_pkg::GCNT_W-1:0]  cpu_count,
    input  wire logic [mfs_pkg::SL_W-1:0]    slice_length,
    output logic                             result_strobe,
    output mfs_pkg::out_item_t               result
);

    localparam int TID_W = mfs_pkg::TID_W;
    localparam int LVL_W = mfs_pkg::LVL_W;
    localparam int CNT_W = mfs_pkg::CNT_W;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_FIN_RD = 11'b00000000010,
        ST_REM_RD = 11'b00000000100,
        ST_REM_WR = 11'b00000001000,
        ST_POP_RD = 11'b00000010000,
        ST_POP_WR = 11'b00000100000,
        ST_SW_RD  = 11'b00001000000,
        ST_SW_WR  = 11'b00010000000,
        ST_EM_RD  = 11'b00100000000,
        ST_EM_DAT = 11'b01000000000,
        ST_MUL    = 11'b10000000000
    } state_t;

    // memories
    logic [TID_W-1:0]   fifo_mem [mfs_pkg::LEVELS*mfs_pkg::MAX_TASKS];
    mfs_pkg::task_rec_t task_mem [mfs_pkg::MAX_TASKS];

    logic                        fifo_we;
    logic [mfs_pkg::FADDR_W-1:0] fifo_waddr, fifo_raddr;
    logic [TID_W-1:0]            fifo_wdata, fifo_rdata_reg;
    logic                        task_we;
    logic [TID_W-1:0]            task_waddr, task_raddr;
    mfs_pkg::task_rec_t          task_wdata, task_rdata_reg;

    // control state
    state_t                       state_reg, state_next;
    logic [mfs_pkg::MAX_TASKS-1:0] live_reg, live_next;
    logic [mfs_pkg::MAX_TASKS-1:0] granted_reg, granted_next;
    logic [TID_W-1:0]   head_reg  [mfs_pkg::LEVELS], head_next  [mfs_pkg::LEVELS];
    logic [TID_W-1:0]   tail_reg  [mfs_pkg::LEVELS], tail_next  [mfs_pkg::LEVELS];
    logic [CNT_W-1:0]   count_reg [mfs_pkg::LEVELS], count_next [mfs_pkg::LEVELS];
    logic [TID_W-1:0]   gid_reg   [mfs_pkg::MAX_CPUS], gid_next [mfs_pkg::MAX_CPUS];
    mfs_pkg::cmd_t               cmd_reg, cmd_next;
    logic [LVL_W-1:0]            lvl_reg, lvl_next;
    logic [LVL_W-1:0]            nl_reg, nl_next;
    logic [mfs_pkg::GCNT_W-1:0]  grants_reg, grants_next;
    logic [mfs_pkg::GIX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]            rem_n_reg, rem_n_next;
    logic [CNT_W-1:0]            rem_i_reg, rem_i_next;
    logic [TID_W-1:0]            tptr_reg, tptr_next;
    logic [mfs_pkg::SL_W-1:0]    run_reg, run_next;
    logic [mfs_pkg::SL_W-1:0]    wait_reg, wait_next;
    logic [mfs_pkg::TIME_W-1:0]  prun_reg, pwait_reg;
    logic                        res_strobe_reg, res_strobe_next;
    mfs_pkg::out_item_t          res_reg, res_next;

    logic                        any_queued;
    logic [LVL_W-1:0]            top_lvl;
    logic [mfs_pkg::GCNT_W-1:0]  cpus;
    logic [mfs_pkg::GCNT_W-1:0]  grant_cnt;
    mfs_pkg::task_rec_t          rec;
    mfs_pkg::cmd_t               icmd;

    // highest-priority (lowest-numbered) non-empty level
    always_comb
    begin
        any_queued = 1'b0;
        top_lvl    = '0;
        for (int l = mfs_pkg::LEVELS - 1; l >= 0; l--)
        begin
            if (count_reg[l] != '0)
            begin
                any_queued = 1'b1;
                top_lvl    = LVL_W'(l);
            end
        end
    end

    // effective cpu count and grants for this tick
    always_comb
    begin
        if (cpu_count == '0)
            cpus = mfs_pkg::GCNT_W'(1);
        else if (cpu_count > mfs_pkg::GCNT_W'(mfs_pkg::MAX_CPUS))
            cpus = mfs_pkg::GCNT_W'(mfs_pkg::MAX_CPUS);
        else
            cpus = cpu_count;
        if (count_reg[top_lvl] < CNT_W'(cpus))
            grant_cnt = count_reg[top_lvl][mfs_pkg::GCNT_W-1:0];
        else
            grant_cnt = cpus;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        live_next       = live_reg;
        granted_next    = granted_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        gid_next        = gid_reg;
        cmd_next        = cmd_reg;
        lvl_next        = lvl_reg;
        nl_next         = nl_reg;
        grants_next     = grants_reg;
        idx_next        = idx_reg;
        rem_n_next      = rem_n_reg;
        rem_i_next      = rem_i_reg;
        tptr_next       = tptr_reg;
        run_next        = run_reg;
        wait_next       = wait_reg;
        res_strobe_next = 1'b0;
        res_next        = res_reg;
        pop             = 1'b0;
        fifo_we         = 1'b0;
        fifo_waddr      = {lvl_reg, tail_reg[lvl_reg]};
        fifo_wdata      = cmd_reg.id;
        fifo_raddr      = {lvl_reg, head_reg[lvl_reg]};
        task_we         = 1'b0;
        task_waddr      = tptr_reg;
        task_wdata      = task_rdata_reg;
        task_raddr      = tptr_reg;
        rec             = task_rdata_reg;
        icmd            = front_out.cmd;

        case (state_reg)
            ST_IDLE:
            begin
                if (front_out.valid)
                begin
                    pop      = 1'b1;
                    cmd_next = icmd;
                    // default result: reject
                    res_next.kind        = mfs_pkg::KIND_REJECT;
                    res_next.task_id_out = icmd.id;
                    res_next.level_out   = '0;
                    res_next.run_time    = '0;
                    res_next.wait_time   = '0;
                    res_next.last        = 1'b1;
                    res_strobe_next      = 1'b1;
                    case (icmd.code)
                        mfs_pkg::CMD_SUBMIT:
                        begin
                            if (!live_reg[icmd.id])
                            begin
                                live_next[icmd.id]    = 1'b1;
                                task_we               = 1'b1;
                                task_waddr            = icmd.id;
                                task_wdata.level      = icmd.lvl;
                                task_wdata.run        = '0;
                                task_wdata.waits      = '0;
                                fifo_we               = 1'b1;
                                fifo_waddr            = {icmd.lvl, tail_reg[icmd.lvl]};
                                fifo_wdata            = icmd.id;
                                tail_next[icmd.lvl]   = tail_reg[icmd.lvl] + 1'b1;
                                count_next[icmd.lvl]  = count_reg[icmd.lvl] + 1'b1;
                                res_next.kind         = mfs_pkg::KIND_IDLE;
                                res_next.level_out    = icmd.lvl;
                            end
                        end
                        mfs_pkg::CMD_FINISH:
                        begin
                            if (live_reg[icmd.id])
                            begin
                                res_strobe_next = 1'b0;
                                task_raddr      = icmd.id;
                                state_next      = ST_FIN_RD;
                            end
                        end
                        mfs_pkg::CMD_TICK:
                        begin
                            if (!any_queued)
                            begin
                                res_next.kind        = mfs_pkg::KIND_IDLE;
                                res_next.task_id_out = '0;
                            end
                            else
                            begin
                                res_strobe_next = 1'b0;
                                lvl_next        = top_lvl;
                                nl_next         = (top_lvl == LVL_W'(mfs_pkg::LEVELS - 1))
                                                ? top_lvl : top_lvl + 1'b1;
                                grants_next     = grant_cnt;
                                idx_next        = '0;
                                granted_next    = '0;
                                state_next      = ST_POP_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // finish: record is now readable
            ST_FIN_RD:
            begin
                lvl_next   = rec.level;
                run_next   = rec.run;
                wait_next  = rec.waits;
                rem_n_next = count_reg[rec.level];
                rem_i_next = '0;
                if (count_reg[rec.level] == '0)
                begin
                    live_next[cmd_reg.id] = 1'b0;
                    state_next            = ST_MUL;
                end
                else
                    state_next = ST_REM_RD;
            end

            // rotate the level once, dropping the finished task
            ST_REM_RD:
            begin
                fifo_raddr = {lvl_reg, head_reg[lvl_reg]};
                state_next = ST_REM_WR;
            end

            ST_REM_WR:
            begin
                head_next[lvl_reg] = head_reg[lvl_reg] + 1'b1;
                if (fifo_rdata_reg != cmd_reg.id)
                begin
                    fifo_we            = 1'b1;
                    fifo_waddr         = {lvl_reg, tail_reg[lvl_reg]};
                    fifo_wdata         = fifo_rdata_reg;
                    tail_next[lvl_reg] = tail_reg[lvl_reg] + 1'b1;
                end
                else
                    count_next[lvl_reg] = count_reg[lvl_reg] - 1'b1;
                rem_i_next = rem_i_reg + 1'b1;
                if (rem_i_reg + 1'b1 == rem_n_reg)
                begin
                    live_next[cmd_reg.id] = 1'b0;
                    state_next            = ST_MUL;
                end
                else
                    state_next = ST_REM_RD;
            end

            // tick: pop the granted tasks
            ST_POP_RD:
            begin
                fifo_raddr = {lvl_reg, head_reg[lvl_reg]};
                state_next = ST_POP_WR;
            end

            ST_POP_WR:
            begin
                gid_next[idx_reg]             = fifo_rdata_reg;
                granted_next[fifo_rdata_reg]  = 1'b1;
                head_next[lvl_reg]            = head_reg[lvl_reg] + 1'b1;
                count_next[lvl_reg]           = count_reg[lvl_reg] - 1'b1;
                idx_next                      = idx_reg + 1'b1;
                if (mfs_pkg::GCNT_W'(idx_reg) + 1'b1 == grants_reg)
                begin
                    tptr_next  = '0;
                    state_next = ST_SW_RD;
                end
                else
                    state_next = ST_POP_RD;
            end

            // tick: sweep all tasks, update slice counters
            ST_SW_RD:
            begin
                task_raddr = tptr_reg;
                state_next = ST_SW_WR;
            end

            ST_SW_WR:
            begin
                if (live_reg[tptr_reg])
                begin
                    task_we    = 1'b1;
                    task_waddr = tptr_reg;
                    task_wdata = rec;
                    if (granted_reg[tptr_reg])
                    begin
                        task_wdata.level = nl_reg;
                        if (rec.run != mfs_pkg::SLICE_SAT)
                            task_wdata.run = rec.run + 1'b1;
                    end
                    else if (rec.waits != mfs_pkg::SLICE_SAT)
                        task_wdata.waits = rec.waits + 1'b1;
                end
                tptr_next = tptr_reg + 1'b1;
                if (tptr_reg == TID_W'(mfs_pkg::MAX_TASKS - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_EM_RD;
                end
                else
                    state_next = ST_SW_RD;
            end

            // tick: requeue one granted task and fetch its record
            ST_EM_RD:
            begin
                task_raddr        = gid_reg[idx_reg];
                fifo_we           = 1'b1;
                fifo_waddr        = {nl_reg, tail_reg[nl_reg]};
                fifo_wdata        = gid_reg[idx_reg];
                tail_next[nl_reg] = tail_reg[nl_reg] + 1'b1;
                count_next[nl_reg] = count_reg[nl_reg] + 1'b1;
                state_next        = ST_EM_DAT;
            end

            ST_EM_DAT:
            begin
                run_next   = rec.run;
                wait_next  = rec.waits;
                state_next = ST_MUL;
            end

            // products land this edge; emit the report
            ST_MUL:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // emit after the multiply registers are loaded; one pulse per report
    logic out_pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_pend_reg <= 1'b0;
        else
            out_pend_reg <= (state_reg == ST_MUL) && !out_pend_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            live_reg       <= '0;
            granted_reg    <= '0;
            head_reg       <= '{default: '0};
            tail_reg       <= '{default: '0};
            count_reg      <= '{default: '0};
            res_strobe_reg <= 1'b0;
            idx_reg        <= '0;
            grants_reg     <= '0;
            rem_i_reg      <= '0;
            rem_n_reg      <= '0;
            tptr_reg       <= '0;
        end
        else
        begin
            live_reg    <= live_next;
            granted_reg <= granted_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            grants_reg  <= grants_next;
            rem_i_reg   <= rem_i_next;
            rem_n_reg   <= rem_n_next;
            tptr_reg    <= tptr_next;
            if (out_pend_reg)
            begin
                // report cycle: advance through grants or return idle
                res_strobe_reg <= 1'b1;
                if (cmd_reg.code == mfs_pkg::CMD_TICK &&
                    mfs_pkg::GCNT_W'(idx_reg) + 1'b1 != grants_reg)
                begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= ST_EM_RD;
                end
                else
                begin
                    idx_reg   <= idx_next;
                    state_reg <= ST_IDLE;
                end
            end
            else
            begin
                res_strobe_reg <= res_strobe_next;
                idx_reg        <= idx_next;
                state_reg      <= (state_next == ST_IDLE && state_reg == ST_MUL)
                                ? ST_MUL : state_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        gid_reg   <= gid_next;
        cmd_reg   <= cmd_next;
        lvl_reg   <= lvl_next;
        nl_reg    <= nl_next;
        run_reg   <= run_next;
        wait_reg  <= wait_next;
        prun_reg  <= mfs_pkg::TIME_W'(run_reg) * mfs_pkg::TIME_W'(slice_length);
        pwait_reg <= mfs_pkg::TIME_W'(wait_reg) * mfs_pkg::TIME_W'(slice_length);
        if (out_pend_reg)
        begin
            res_reg.run_time  <= prun_reg;
            res_reg.wait_time <= pwait_reg;
            res_reg.level_out <= lvl_reg;
            if (cmd_reg.code == mfs_pkg::CMD_TICK)
            begin
                res_reg.kind        <= mfs_pkg::KIND_GRANT;
                res_reg.task_id_out <= gid_reg[idx_reg];
                res_reg.last        <= (mfs_pkg::GCNT_W'(idx_reg) + 1'b1 == grants_reg);
            end
            else
            begin
                res_reg.kind        <= mfs_pkg::KIND_FINISH;
                res_reg.task_id_out <= cmd_reg.id;
                res_reg.last        <= 1'b1;
            end
        end
        else
            res_reg <= res_next;
    end

    // level FIFO storage
    always_ff @(posedge clk)
    begin
        if (fifo_we)
            fifo_mem[fifo_waddr] <= fifo_wdata;
        fifo_rdata_reg <= fifo_mem[fifo_raddr];
    end

    // task record storage
    always_ff @(posedge clk)
    begin
        if (task_we)
            task_mem[task_waddr] <= task_wdata;
        task_rdata_reg <= task_mem[task_raddr];
    end

    assign result_strobe = res_strobe_reg;
    assign result        = res_reg;

endmodule

`default_nettype wire

/* hw/rtl/multilevel_feedback_scheduler_core.sv */
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_core
// Four-level feedback scheduler: submit, tick and finish items in, grant,
// report, accept/idle and reject results out.
//
//  channel  | signals                               | handshake
//  ---------+---------------------------------------+-------------------------
//  input    | start, busy, item                     | start && !busy
//  result   | result_strobe, result                 | one-cycle strobe
//  config   | cfg_we, cfg_index, cfg_data           | write on cfg_we
//
// Submit, reject and idle tick complete in ST_IDLE of the back end.
// Finish: reads the task record, then rotates its level FIFO to drop the task.
// Tick: pops G grants, sweeps all task records through the single record
// memory port, then requeues and reports each grant.
// A two-item queue decouples input from execution; busy is high when full.
// No clearing pass after reset; results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module multilevel_feedback_scheduler_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire mfs_pkg::in_item_t         item,
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_index,
    input  wire logic [mfs_pkg::SL_W-1:0]  cfg_data,
    output logic                           result_strobe,
    output mfs_pkg::out_item_t             result
);

    logic [mfs_pkg::GCNT_W-1:0] cpu_count_reg;
    logic [mfs_pkg::SL_W-1:0]   slice_length_reg;
    mfs_pkg::front_out_t        front_out;
    logic                       pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_count_reg    <= mfs_pkg::GCNT_W'(1);
            slice_length_reg <= mfs_pkg::SL_W'(10);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mfs_pkg::REG_CPU_COUNT:    cpu_count_reg    <= cfg_data[mfs_pkg::GCNT_W-1:0];
                mfs_pkg::REG_SLICE_LENGTH: slice_length_reg <= cfg_data;
                default:                   cpu_count_reg    <= cpu_count_reg;
            endcase
        end
    end

    mfs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .pop       (pop),
        .front_out (front_out)
    );

    mfs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .front_out     (front_out),
        .pop           (pop),
        .cpu_count     (cpu_count_reg),
        .slice_length  (slice_length_reg),
        .result_strobe (result_strobe),
        .result        (result)
    );

    // single-result items always close their sequence
    `ASSERT_IMPLY(a_single_last, result_strobe && result.kind != mfs_pkg::KIND_GRANT, result.last)
    // rejects carry no level or times
    `ASSERT_IMPLY(a_reject_clean, result_strobe && result.kind == mfs_pkg::KIND_REJECT, result.level_out == '0 && result.run_time == '0 && result.wait_time == '0)
    // accept and idle results carry no times
    `ASSERT_NEVER(a_idle_times, result_strobe && result.kind == mfs_pkg::KIND_IDLE && (result.run_time != '0 || result.wait_time != '0))

endmodule

`default_nettype wire
